/* rtl/obgr_pkg.sv */
// Shared types, sizes and codes of the obstacle grid rasterizer.
// Used by every RTL file and the checker; depends on nothing.
package obgr_pkg;

    // Array and coordinate sizes
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int COORD_BITS = 16;

    localparam int MAX_DIM   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int IDX_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // doubled cell coordinates reach 2*MAX_DIM*cell_side
    localparam int P_W   = COORD_BITS + $clog2(MAX_DIM) + 1;
    localparam int SQ_W  = 2 * P_W;
    localparam int LIM_W = COORD_BITS + 1;

    // Commands
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_RECT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CIRCLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_CNT_W  = 7;
    localparam int CFG_DATA_W = (COORD_BITS > CFG_CNT_W) ? COORD_BITS : CFG_CNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;
    localparam logic [COORD_BITS-1:0] CELL_SIDE_RST = COORD_BITS'(16);
    localparam logic [CFG_CNT_W-1:0]  COLS_RST      = CFG_CNT_W'(64);
    localparam logic [CFG_CNT_W-1:0]  ROWS_RST      = CFG_CNT_W'(64);

    // Result count
    localparam int CNT_W = 13;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Distance unit token kinds
    localparam int TOK_W = 2;
    localparam logic [TOK_W-1:0] TOK_RADIUS = 2'd0;
    localparam logic [TOK_W-1:0] TOK_ROW    = 2'd1;
    localparam logic [TOK_W-1:0] TOK_COL    = 2'd2;

    // Stream payloads
    localparam int CELL_IDX_W = 6;
    localparam int IN_BITS    = CMD_W + 5 * COORD_BITS + 2 * CELL_IDX_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + CNT_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [CELL_IDX_W-1:0] cell_row;
        logic [CELL_IDX_W-1:0] cell_col;
        logic [COORD_BITS-1:0] circle_radius;
        logic [COORD_BITS-1:0] rect_height;
        logic [COORD_BITS-1:0] rect_width;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-1:0] center_x;
        logic [CMD_W-1:0]      cmd;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] cells_covered;
        logic             cell_occupied;
    } t_out_item;

    // Controller -> datapath
    typedef struct packed {
        logic              accept;
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
        logic              issue_radius;
        logic              issue_row;
        logic              issue_col;
        logic [IDX_W-1:0]  idx;
        logic              mem_rd;
        logic              out_load;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic                 busy;
        logic                 out_free;
        logic [COL_CNT_W-1:0] ncols;
        logic [ROW_CNT_W-1:0] nrows;
    } t_dp_sts;

endpackage

/* rtl/obgr_ctrl.sv */
// Sequencer of the obstacle grid rasterizer: clear pass, grid walk, read, result.
// Depends on obgr_pkg.
module obgr_ctrl import obgr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic         o_ready,
    output t_dp_cmd      o_ctl,
    input  t_dp_sts      i_sts
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RADIUS = 3'd2;
    localparam logic [2:0] ST_ROW    = 3'd3;
    localparam logic [2:0] ST_COL    = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              accept;
    logic              last_col;
    logic              last_row;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign last_col = (COL_CNT_W'(r_col) + COL_CNT_W'(1)) == i_sts.ncols;
    assign last_row = (ROW_CNT_W'(r_row) + ROW_CNT_W'(1)) == i_sts.nrows;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_col   = r_col;
        n_row   = r_row;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd) inside
                        CMD_RECT, CMD_CIRCLE: begin
                            if (i_sts.ncols == '0 || i_sts.nrows == '0) begin
                                n_state = ST_FINISH;
                            end else begin
                                n_state = ST_RADIUS;
                            end
                        end
                        CMD_READ: n_state = ST_READ;
                        default:  n_state = ST_FINISH;
                    endcase
                end
            end
            ST_RADIUS: begin
                n_row   = '0;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                n_col   = '0;
                n_state = ST_COL;
            end
            ST_COL: begin
                if (last_col) begin
                    if (last_row) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_state = ST_ROW;
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_READ: n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_comb begin
        o_ctl.accept       = accept;
        o_ctl.clr_we       = (r_state == ST_CLEAR);
        o_ctl.clr_addr     = r_clr;
        o_ctl.issue_radius = (r_state == ST_RADIUS);
        o_ctl.issue_row    = (r_state == ST_ROW);
        o_ctl.issue_col    = (r_state == ST_COL);
        o_ctl.idx          = (r_state == ST_ROW) ? IDX_W'(r_row) : IDX_W'(r_col);
        o_ctl.mem_rd       = (r_state == ST_READ);
        o_ctl.out_load     = (r_state == ST_FINISH) && i_sts.out_free;
    end

endmodule

/* rtl/obgr_dp.sv */
// Datapath of the obstacle grid rasterizer: config registers, coordinate walkers,
// pipelined distance/square unit, occupancy memory and result register. Uses obgr_pkg.
module obgr_dp import obgr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_item,
    input  t_dp_cmd               i_ctl,
    output t_dp_sts               o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out_item
);

    // ---------------- configuration ----------------
    logic [COORD_BITS-1:0] r_cell_side;
    logic [CFG_CNT_W-1:0]  r_cols_cfg;
    logic [CFG_CNT_W-1:0]  r_rows_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_side <= CELL_SIDE_RST;
            r_cols_cfg  <= COLS_RST;
            r_rows_cfg  <= ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELL_SIDE: r_cell_side <= COORD_BITS'(i_cfg_data);
                CFG_COLS:      r_cols_cfg  <= CFG_CNT_W'(i_cfg_data);
                CFG_ROWS:      r_rows_cfg  <= CFG_CNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_sts.ncols = (32'(r_cols_cfg) > MAX_COLS) ? COL_CNT_W'(MAX_COLS)
                                                      : COL_CNT_W'(r_cols_cfg);
    assign o_sts.nrows = (32'(r_rows_cfg) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS)
                                                      : ROW_CNT_W'(r_rows_cfg);

    // ---------------- item latch ----------------
    logic [CMD_W-1:0]  r_cmd;
    logic [P_W-1:0]    r_cx2, r_cy2, r_r2;
    logic [LIM_W-1:0]  r_xlim, r_ylim;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd     <= i_item.cmd;
            r_cx2     <= P_W'({i_item.center_x, 1'b0});
            r_cy2     <= P_W'({i_item.center_y, 1'b0});
            r_r2      <= P_W'({i_item.circle_radius, 1'b0});
            r_xlim    <= LIM_W'(i_item.rect_width) + LIM_W'(r_cell_side);
            r_ylim    <= LIM_W'(i_item.rect_height) + LIM_W'(r_cell_side);
            r_rd_addr <= {ROW_W'(i_item.cell_row), COL_W'(i_item.cell_col)};
            r_rd_ok   <= (32'(i_item.cell_col) < MAX_COLS) && (32'(i_item.cell_row) < MAX_ROWS);
        end
    end

    // ---------------- doubled cell centre walkers ----------------
    logic [P_W-1:0] s_p, s2_p;
    logic [P_W-1:0] r_px, r_py;

    assign s_p  = P_W'(r_cell_side);
    assign s2_p = P_W'({r_cell_side, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_py <= s_p;
        end else if (i_ctl.issue_row) begin
            r_py <= r_py + s2_p;
        end
        if (i_ctl.issue_row) begin
            r_px <= s_p;
        end else if (i_ctl.issue_col) begin
            r_px <= r_px + s2_p;
        end
    end

    // ---------------- distance unit, issue ----------------
    logic             issue;
    logic [TOK_W-1:0] tok_kind;
    logic [P_W-1:0]   tok_p, tok_c;
    logic [LIM_W-1:0] tok_lim;
    logic [P_W:0]     diff0;
    logic [P_W-1:0]   dx0;

    assign issue = i_ctl.issue_radius | i_ctl.issue_row | i_ctl.issue_col;

    always_comb begin
        if (i_ctl.issue_radius) begin
            tok_kind = TOK_RADIUS;
            tok_p    = r_r2;
            tok_c    = '0;
            tok_lim  = '0;
        end else if (i_ctl.issue_row) begin
            tok_kind = TOK_ROW;
            tok_p    = r_py;
            tok_c    = r_cy2;
            tok_lim  = r_ylim;
        end else begin
            tok_kind = TOK_COL;
            tok_p    = r_px;
            tok_c    = r_cx2;
            tok_lim  = r_xlim;
        end
        diff0 = {1'b0, tok_p} - {1'b0, tok_c};
        dx0   = diff0[P_W] ? P_W'(-diff0) : diff0[P_W-1:0];
    end

    // stage 1: |p - c|
    logic             r_s1_v;
    logic [TOK_W-1:0] r_s1_kind;
    logic [IDX_W-1:0] r_s1_idx;
    logic [P_W-1:0]   r_s1_dx0;
    logic [LIM_W-1:0] r_s1_lim;

    // stage 2: nearest corner offset ||p - c| - s|, linear limit test
    logic             r_s2_v;
    logic [TOK_W-1:0] r_s2_kind;
    logic [IDX_W-1:0] r_s2_idx;
    logic [P_W-1:0]   r_s2_dx0, r_s2_dxm;
    logic             r_s2_lin;
    logic [P_W:0]     diff1;
    logic [P_W-1:0]   dxm;

    assign diff1 = {1'b0, r_s1_dx0} - {1'b0, s_p};
    assign dxm   = diff1[P_W] ? P_W'(-diff1) : diff1[P_W-1:0];

    // stage 3: squares
    logic             r_s3_v;
    logic [TOK_W-1:0] r_s3_kind;
    logic [IDX_W-1:0] r_s3_idx;
    logic [SQ_W-1:0]  r_s3_sq0, r_s3_sqm;
    logic             r_s3_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind <= tok_kind;
        r_s1_idx  <= i_ctl.idx;
        r_s1_dx0  <= dx0;
        r_s1_lim  <= tok_lim;

        r_s2_kind <= r_s1_kind;
        r_s2_idx  <= r_s1_idx;
        r_s2_dx0  <= r_s1_dx0;
        r_s2_dxm  <= dxm;
        r_s2_lin  <= r_s1_dx0 < P_W'(r_s1_lim);

        r_s3_kind <= r_s2_kind;
        r_s3_idx  <= r_s2_idx;
        r_s3_sq0  <= SQ_W'(r_s2_dx0) * SQ_W'(r_s2_dx0);
        r_s3_sqm  <= SQ_W'(r_s2_dxm) * SQ_W'(r_s2_dxm);
        r_s3_lin  <= r_s2_lin;
    end

    assign o_sts.busy = r_s1_v | r_s2_v | r_s3_v;

    // ---------------- final stage: row terms and cell decision ----------------
    logic [SQ_W-1:0]  r_rr, r_dy0sq, r_dymsq;
    logic             r_ylin;
    logic [ROW_W-1:0] r_row_idx;
    logic [SQ_W:0]    sum0, summ;
    logic             circ_hit, cell_hit, mark;

    assign sum0     = (SQ_W+1)'(r_s3_sq0) + (SQ_W+1)'(r_dy0sq);
    assign summ     = (SQ_W+1)'(r_s3_sqm) + (SQ_W+1)'(r_dymsq);
    // centre inside, or the nearest of the four corners inside
    assign circ_hit = (sum0 < (SQ_W+1)'(r_rr)) || (summ < (SQ_W+1)'(r_rr));
    assign cell_hit = (r_cmd == CMD_RECT) ? (r_s3_lin & r_ylin) : circ_hit;
    assign mark     = r_s3_v && (r_s3_kind == TOK_COL) && cell_hit;

    always_ff @(posedge i_clk) begin
        if (r_s3_v) begin
            case (r_s3_kind)
                TOK_RADIUS: r_rr <= r_s3_sq0;
                TOK_ROW: begin
                    r_dy0sq   <= r_s3_sq0;
                    r_dymsq   <= r_s3_sqm;
                    r_ylin    <= r_s3_lin;
                    r_row_idx <= ROW_W'(r_s3_idx);
                end
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_count <= '0;
        end else if (mark && r_count != COUNT_MAX) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // ---------------- occupancy memory ----------------
    logic              mem [MEM_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              r_rd_bit;

    assign mem_we    = i_ctl.clr_we | mark;
    assign mem_waddr = i_ctl.clr_we ? i_ctl.clr_addr : {r_row_idx, COL_W'(r_s3_idx)};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= !i_ctl.clr_we;
        end
        if (i_ctl.mem_rd) begin
            r_rd_bit <= mem[r_rd_addr];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_out_item.cell_occupied <= (r_cmd == CMD_READ) && r_rd_ok && r_rd_bit;
            o_out_item.cells_covered <= r_count;
        end
    end

    assign o_sts.out_free = !o_out_valid || i_out_ready;

endmodule

/* rtl/obstacle_grid_rasterizer_unit.sv */
// Top level of the obstacle grid rasterizer: stream ports, config port,
// controller and datapath. Depends on obgr_pkg, obgr_ctrl, obgr_dp.
//
// Keeps a 64 x 64 one-bit occupancy grid in an on-chip memory and serves three
// commands. After reset the grid is cleared by a pass that writes one cell a
// cycle, during which s_axis_tready stays low (config writes are taken
// throughout). A rectangle or circle add walks the cells in use row by row,
// one cell per cycle, through a shared 3-stage distance/square unit: each row
// first sends one row token (y distances and squares), then one token per
// column; the circle radius squared goes through the same unit once per
// command. An add ends once the unit has drained, or skips the walk when no
// cells are in use; the cell loop through the single distance unit and the
// one-write memory port sets its time. A read goes through a registered
// memory read; an unused command code goes straight to the result. One item
// is in work at a time; the result waits in an output register so the next
// input can be taken while m_axis is stalled. Shape tests are exact on
// doubled coordinates; a circle marks a cell when its centre or its nearest
// corner lies strictly inside. Config writes are to be made only while idle.
module obstacle_grid_rasterizer_unit import obgr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // cmd, center_x, center_y, rect_width, rect_height, circle_radius,
    // cell_col, cell_row (from bit 0 up), zero pad to whole bytes
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,
    // cell_occupied, cells_covered (from bit 0 up), zero pad to whole bytes
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,
    // register write: 0 cell_side, 1 cols_in_use, 2 rows_in_use
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_in_item  w_item;
    t_out_item w_out;
    t_dp_cmd   w_ctl;
    t_dp_sts   w_sts;

    assign w_item       = s_axis_tdata[IN_BITS-1:0];
    assign m_axis_tdata = OUT_W'(w_out);

    obgr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_cmd   (w_item.cmd),
        .o_ready (s_axis_tready),
        .o_ctl   (w_ctl),
        .i_sts   (w_sts)
    );

    obgr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_item  (w_out)
    );

endmodule

/* rtl/obgr_chk.sv */
// Port-level checks of obstacle_grid_rasterizer_unit, attached by bind.
// Depends on obgr_pkg.
module obgr_chk import obgr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // clear pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during clear pass");

    // one item in work at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // occupied bit only on reads, which cover nothing
    a_occ_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[CNT_W:1] == '0)
        else $error("occupied bit with nonzero count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[CNT_W:1] <= CNT_W'(MAX_COLS * MAX_ROWS))
        else $error("count beyond grid size");

endmodule

bind obstacle_grid_rasterizer_unit obgr_chk u_obgr_chk (.*);

/* verif/tb_obstacle_grid_rasterizer_unit.sv */
// Self-checking bench for obstacle_grid_rasterizer_unit: directed table, then random phases.
// Holds an occupancy grid predictor; checks every result against it or the typed row result.
// Depends on obgr_pkg and the RTL top level only.
module tb_obstacle_grid_rasterizer_unit;
    import obgr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int HOLD_AT      = 28;     // result count that triggers the long sink stall
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 25000;  // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_item             item;
        bit                   typed;   // expected result written in the row
        t_out_item            want;
    } t_plan_row;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    // cmd, center_x, center_y, rect_width, rect_height, circle_radius,
    // cell_col, cell_row (from bit 0 up), zero pad
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata   = '0;
    // cell_occupied, cells_covered (from bit 0 up), zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // predictor state: grid contents and the register copies
    bit                    occ_map [MAX_ROWS][MAX_COLS];
    logic [COORD_BITS-1:0] grid_side = CELL_SIDE_RST;
    logic [CFG_CNT_W-1:0]  pred_cols = COLS_RST;
    logic [CFG_CNT_W-1:0]  pred_rows = ROWS_RST;

    t_out_item  due_results [$];
    t_plan_row  directed_plan [$];
    int         mismatches   = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;
    bit         steady_flow  = 1'b0;   // both sides run without gaps while set

    obstacle_grid_rasterizer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint abs_dist(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // strict test on doubled coordinates, compared squared
    function automatic bit point_inside(longint px, longint py, longint cx, longint cy,
                                        longint r);
        longint dx, dy;
        dx = abs_dist(px, cx);
        dy = abs_dist(py, cy);
        return dx * dx + dy * dy < r * r;
    endfunction

    // counts above the array size clamp to it
    function automatic int in_use(logic [CFG_CNT_W-1:0] cnt, int cap);
        return (int'(cnt) > cap) ? cap : int'(cnt);
    endfunction

    function automatic int clip16(longint v);
        return (v > 65535) ? 65535 : int'(v);
    endfunction

    // Marks the cells a shape covers and returns the result the block owes.
    function automatic t_out_item rasterize_item(t_in_item it);
        t_out_item res;
        longint    s, cx2, cy2, rw, rh, r2, px2, py2;
        int        nc, nr;
        bit        hit;
        res = '0;
        s   = longint'(grid_side);
        cx2 = 2 * longint'(it.center_x);
        cy2 = 2 * longint'(it.center_y);
        rw  = longint'(it.rect_width);
        rh  = longint'(it.rect_height);
        r2  = 2 * longint'(it.circle_radius);
        nc  = in_use(pred_cols, MAX_COLS);
        nr  = in_use(pred_rows, MAX_ROWS);
        case (it.cmd)
            CMD_RECT, CMD_CIRCLE: begin
                for (int c = 0; c < nc; c++) begin
                    px2 = longint'(2 * c + 1) * s;
                    for (int r = 0; r < nr; r++) begin
                        py2 = longint'(2 * r + 1) * s;
                        if (it.cmd == CMD_RECT) begin
                            hit = abs_dist(px2, cx2) < rw + s && abs_dist(py2, cy2) < rh + s;
                        end else begin
                            // centre or any corner strictly inside
                            hit = point_inside(px2, py2, cx2, cy2, r2)
                               || point_inside(px2 - s, py2 - s, cx2, cy2, r2)
                               || point_inside(px2 + s, py2 - s, cx2, cy2, r2)
                               || point_inside(px2 - s, py2 + s, cx2, cy2, r2)
                               || point_inside(px2 + s, py2 + s, cx2, cy2, r2);
                        end
                        if (hit) begin
                            occ_map[r][c] = 1'b1;
                            if (res.cells_covered != COUNT_MAX)
                                res.cells_covered = res.cells_covered + 1'b1;
                        end
                    end
                end
            end
            CMD_READ: begin
                // stored bit is returned even outside the area in use
                res.cell_occupied = occ_map[it.cell_row][it.cell_col];
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int draw_gap();
        return steady_flow ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic t_plan_row item_row(logic [CMD_W-1:0] cmd,
                                           logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                                           logic [COORD_BITS-1:0] wd, logic [COORD_BITS-1:0] ht,
                                           logic [COORD_BITS-1:0] rad,
                                           logic [CELL_IDX_W-1:0] col,
                                           logic [CELL_IDX_W-1:0] rw,
                                           bit typed = 1'b0, bit w_occ = 1'b0, int w_cnt = 0);
        t_plan_row p;
        p.is_cfg             = 1'b0;
        p.idx                = '0;
        p.data               = '0;
        p.item.cmd           = cmd;
        p.item.center_x      = cx;
        p.item.center_y      = cy;
        p.item.rect_width    = wd;
        p.item.rect_height   = ht;
        p.item.circle_radius = rad;
        p.item.cell_col      = col;
        p.item.cell_row      = rw;
        p.typed              = typed;
        p.want.cell_occupied = w_occ;
        p.want.cells_covered = CNT_W'(w_cnt);
        return p;
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        t_plan_row p;
        p        = item_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
        p.is_cfg = 1'b1;
        p.idx    = idx;
        p.data   = data;
        return p;
    endfunction

    // Mostly aimed at the area in use so shapes land on cells and reads find
    // marks; the rest keeps full-range values so every field bit toggles.
    function automatic t_in_item random_item();
        t_in_item it;
        int       nc, nr, pick, reach_x, reach_y, size_top;
        it.center_x      = COORD_BITS'($urandom);
        it.center_y      = COORD_BITS'($urandom);
        it.rect_width    = COORD_BITS'($urandom);
        it.rect_height   = COORD_BITS'($urandom);
        it.circle_radius = COORD_BITS'($urandom);
        it.cell_col      = CELL_IDX_W'($urandom);
        it.cell_row      = CELL_IDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 34)
            it.cmd = CMD_RECT;
        else if (pick < 68)
            it.cmd = CMD_CIRCLE;
        else if (pick < 95)
            it.cmd = CMD_READ;
        else
            it.cmd = CMD_UNUSED;
        nc = in_use(pred_cols, MAX_COLS);
        nr = in_use(pred_rows, MAX_ROWS);
        if ($urandom_range(0, 4) != 0) begin
            reach_x  = clip16(longint'(nc + 1) * longint'(grid_side));
            reach_y  = clip16(longint'(nr + 1) * longint'(grid_side));
            size_top = clip16(3 * longint'(grid_side) + 2);
            it.center_x      = COORD_BITS'($urandom_range(0, reach_x));
            it.center_y      = COORD_BITS'($urandom_range(0, reach_y));
            it.rect_width    = COORD_BITS'($urandom_range(0, size_top));
            it.rect_height   = COORD_BITS'($urandom_range(0, size_top));
            it.circle_radius = COORD_BITS'($urandom_range(0, size_top));
            if (nc > 0)
                it.cell_col = CELL_IDX_W'($urandom_range(0, nc - 1));
            if (nr > 0)
                it.cell_row = CELL_IDX_W'($urandom_range(0, nr - 1));
        end
        return it;
    endfunction

    // Offers one item, waits for its transfer, then books the expected result.
    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        int        gap;
        t_out_item calc;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(it);
        do @(posedge i_clk); while (!s_axis_tready);
        calc = rasterize_item(it);
        due_results.push_back(typed ? want : calc);
    endtask

    // Source goes quiet until every booked result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
    endtask

    // Only called while the block is idle; the extra edge keeps write enable
    // from being dropped and raised in one step on back-to-back writes.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CELL_SIDE: grid_side = data[COORD_BITS-1:0];
            CFG_COLS:      pred_cols = data[CFG_CNT_W-1:0];
            CFG_ROWS:      pred_rows = data[CFG_CNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Source side: reset, directed table, random phases, end of run
    // ------------------------------------------------------------------
    initial begin
        logic [COORD_BITS-1:0] side;
        int                    cols, rows, n_items;

        // Default config: 16-unit cells over 64 x 64.
        // Fresh grid reads clear, the unused code is ignored.
        directed_plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        directed_plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 63, 63, 1, 0, 0));
        directed_plan.push_back(item_row(CMD_UNUSED, '1, '1, '1, '1, '1, 63, 63, 1, 0, 0));
        // widest rectangle, zero height, on row 0: the whole first row
        directed_plan.push_back(item_row(CMD_RECT, 0, 8, '1, 0, 0, 0, 0, 1, 0, 64));
        directed_plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 63, 0, 1, 1, 0));
        directed_plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
        // circle centred on a cell corner
        directed_plan.push_back(item_row(CMD_CIRCLE, 512, 512, 0, 0, 40, 0, 0));
        // zero radius covers nothing
        directed_plan.push_back(item_row(CMD_CIRCLE, 300, 700, 0, 0, 0, 0, 0, 1, 0, 0));
        directed_plan.push_back(item_row(CMD_RECT, '1, '1, '1, '1, 0, 0, 0));
        directed_plan.push_back(item_row(CMD_CIRCLE, '1, '1, 0, 0, '1, 0, 0));
        directed_plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 32, 32));
        directed_plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 31, 31));
        // column count field is 7 bits: upper data bits drop, zero columns in use
        directed_plan.push_back(cfg_row(CFG_COLS, 16'hFF80));
        directed_plan.push_back(item_row(CMD_RECT, 0, 0, '1, '1, 0, 0, 0, 1, 0, 0));
        directed_plan.push_back(item_row(CMD_CIRCLE, 0, 0, 0, 0, '1, 0, 0, 1, 0, 0));
        // marks outside the area in use are kept
        directed_plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 63, 0, 1, 1, 0));
        // column count above the array clamps to it
        directed_plan.push_back(cfg_row(CFG_COLS, 127));
        directed_plan.push_back(cfg_row(CFG_ROWS, 1));
        directed_plan.push_back(item_row(CMD_CIRCLE, 0, 0, 0, 0, 16'h0400, 0, 0));
        // zero cell side: every centre and corner at the origin
        directed_plan.push_back(cfg_row(CFG_CELL_SIDE, 0));
        directed_plan.push_back(cfg_row(CFG_COLS, 3));
        directed_plan.push_back(cfg_row(CFG_ROWS, 2));
        directed_plan.push_back(item_row(CMD_RECT, 0, 0, 0, 0, 0, 0, 0));
        directed_plan.push_back(item_row(CMD_RECT, 0, 0, 1, 1, 0, 0, 0));
        directed_plan.push_back(item_row(CMD_CIRCLE, 0, 0, 0, 0, 1, 0, 0));
        directed_plan.push_back(item_row(CMD_CIRCLE, '1, 0, 0, 0, '1, 0, 0));
        // largest cell side
        directed_plan.push_back(cfg_row(CFG_CELL_SIDE, 16'hFFFF));
        directed_plan.push_back(cfg_row(CFG_COLS, 2));
        directed_plan.push_back(cfg_row(CFG_ROWS, 2));
        directed_plan.push_back(item_row(CMD_RECT, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0));
        directed_plan.push_back(item_row(CMD_CIRCLE, '1, '1, 0, 0, '1, 0, 0));
        directed_plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 1, 1));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k]) begin
            if (directed_plan[k].is_cfg) begin
                wait_drained();
                write_reg(directed_plan[k].idx, directed_plan[k].data);
            end else begin
                send_item(directed_plan[k].item, directed_plan[k].typed, directed_plan[k].want);
            end
        end

        // Random phases. Full grids are slow (one cell per cycle), so most
        // phases keep the area in use small and only one runs at 64 x 64.
        for (int ph = 0; ph < 7; ph++) begin
            steady_flow = 1'b0;
            case (ph)
                0: begin side = 16; cols = 8; rows = 8; n_items = 20; end
                1: begin
                    side = COORD_BITS'($urandom_range(1, 64));
                    cols = $urandom_range(1, 16);
                    rows = $urandom_range(1, 16);
                    n_items = 24;
                end
                2: begin side = 0; cols = 5; rows = 7; n_items = 14; steady_flow = 1'b1; end
                3: begin
                    side = '1; cols = 2; rows = 3; n_items = 14;
                    steady_flow = 1'b1;
                end
                4: begin
                    // clamped column count, any cell side
                    side = COORD_BITS'($urandom);
                    cols = 127;
                    rows = $urandom_range(1, 2);
                    n_items = 18;
                end
                5: begin
                    side = COORD_BITS'($urandom_range(8, 64));
                    cols = MAX_COLS; rows = MAX_ROWS; n_items = 10;
                end
                default: begin
                    side = COORD_BITS'($urandom_range(1, 32));
                    cols = $urandom_range(1, 12);
                    rows = $urandom_range(1, 12);
                    n_items = 20;
                end
            endcase
            wait_drained();
            write_reg(CFG_CELL_SIDE, CFG_DATA_W'(side));
            write_reg(CFG_COLS, CFG_DATA_W'(cols));
            write_reg(CFG_ROWS, CFG_DATA_W'(rows));
            for (int i = 0; i < n_items; i++) begin
                // one mid-phase pause until the block has fully emptied
                if (ph == 1 && i == 12)
                    wait_drained();
                send_item(random_item(), 1'b0, '0);
            end
        end

        steady_flow = 1'b0;
        wait_drained();
        // late strays would still be flagged by the sink
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink side: random backpressure, one long hold, result checks
    // ------------------------------------------------------------------
    initial begin
        int        stall;
        bit        hold_done;
        t_out_item got, want;
        hold_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_gap();
            // long hold while the source keeps offering: the output register
            // fills and the block has to stall its input
            if (!hold_done && results_seen == HOLD_AT) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = t_out_item'(m_axis_tdata[OUT_BITS-1:0]);
            results_seen++;
            if (due_results.size() == 0) begin
                $error("unexpected result transfer: cell_occupied %0d cells_covered %0d",
                       got.cell_occupied, got.cells_covered);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (got.cell_occupied !== want.cell_occupied) begin
                    $error("cell_occupied: expected %0d, got %0d",
                           want.cell_occupied, got.cell_occupied);
                    mismatches++;
                end
                if (got.cells_covered !== want.cells_covered) begin
                    $error("cells_covered: expected %0d, got %0d",
                           want.cells_covered, got.cells_covered);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: the clearing pass after reset and a full-grid add run with no
    // transfer, so STALL_LIMIT is set above the length of both.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
